// ===== design/pst_pkg.sv =====
`default_nettype none

package pst_pkg;

  // Fixed widths of the configuration registers and the result fields.
  localparam int ACTIVE_WIDTH    = 3;
  localparam int SHARE_WIDTH     = 16;
  localparam int SHARE_COUNT     = 4;
  localparam int TIME_WIDTH      = 32;
  localparam int USED_WIDTH      = 32;
  localparam int PROC_WIDTH      = 2;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  localparam logic [ACTIVE_WIDTH-1:0] ACTIVE_RESET = 3'd4;
  localparam logic [SHARE_WIDTH-1:0]  SHARE_RESET  = 16'd1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACTIVE_COUNT = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHARE_ZERO   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHARE_ONE    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHARE_TWO    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHARE_THREE  = 3'd4;

  // Record kinds.
  localparam logic REC_GRANT    = 1'b0;
  localparam logic REC_INTERVAL = 1'b1;

  typedef struct packed {
    logic final_tick;
  } pst_tick_t;

  typedef struct packed {
    logic                  record_kind;
    logic [PROC_WIDTH-1:0] process_index;
    logic [USED_WIDTH-1:0] used_ticks;
    logic [TIME_WIDTH-1:0] begin_time;
    logic [TIME_WIDTH-1:0] end_time;
    logic                  last_of_run;
  } pst_rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic mul_lhs;
    logic mul_rhs;
    logic compare;
    logic update;
    logic load_grant;
    logic load_switch;
    logic load_final;
    logic finish;
  } pst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic multi;
    logic last_cand;
    logic switch_needed;
    logic final_flag;
    logic out_free;
  } pst_status_t;

endpackage

`default_nettype wire

// ===== design/pst_chan_if.sv =====
`default_nettype none

interface pst_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/pst_datapath.sv =====
`default_nettype none

module pst_datapath #(
  parameter int MAX_PROCESSES = 4,
  parameter int COUNT_WIDTH   = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [pst_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [pst_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  input  wire logic                                 final_tick,
  input  wire pst_pkg::pst_cmd_t                    cmd,
  output pst_pkg::pst_status_t                      status,
  output logic                                      rec_valid,
  input  wire logic                                 rec_ready,
  output pst_pkg::pst_rec_t                         rec_data
);
  import pst_pkg::*;

  localparam int IW = $clog2(MAX_PROCESSES);
  localparam int NW = $clog2(MAX_PROCESSES + 1);
  localparam int AW = (NW > ACTIVE_WIDTH) ? NW : ACTIVE_WIDTH;
  localparam int PW = COUNT_WIDTH + SHARE_WIDTH;

  // Configuration registers. A zero share is stored as one.
  logic [ACTIVE_WIDTH-1:0] active_count;
  logic [SHARE_WIDTH-1:0]  shares [SHARE_COUNT];
  logic [SHARE_WIDTH-1:0]  cfg_share;

  // Scheduler state.
  logic [COUNT_WIDTH-1:0] used_counts [MAX_PROCESSES];
  logic [TIME_WIDTH-1:0]  tick_number;
  logic                   interval_open;
  logic [IW-1:0]          running_process;
  logic [TIME_WIDTH-1:0]  interval_start;

  // Working registers of the search.
  logic [IW-1:0]          best;
  logic [COUNT_WIDTH-1:0] best_used;
  logic [SHARE_WIDTH-1:0] best_share;
  logic [IW-1:0]          idx;
  logic [PW-1:0]          prod_lhs;
  logic [PW-1:0]          prod_rhs;
  logic                   final_flag;

  logic [AW-1:0]          active_w;
  logic [AW-1:0]          n_w;
  logic [NW-1:0]          n_eff;
  logic [SHARE_WIDTH-1:0] share_idx;
  logic [COUNT_WIDTH-1:0] used_idx;
  logic [COUNT_WIDTH-1:0] mul_a;
  logic [SHARE_WIDTH-1:0] mul_b;
  logic [PW-1:0]          product;
  logic [COUNT_WIDTH-1:0] used_inc;
  logic [TIME_WIDTH-1:0]  tick_plus;
  logic                   any_load;

  assign cfg_share = (cfg_data == '0) ? SHARE_RESET : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= ACTIVE_RESET;
      for (int k = 0; k < SHARE_COUNT; k++) begin
        shares[k] <= SHARE_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_COUNT: active_count <= cfg_data[ACTIVE_WIDTH-1:0];
        REG_SHARE_ZERO:   shares[0] <= cfg_share;
        REG_SHARE_ONE:    shares[1] <= cfg_share;
        REG_SHARE_TWO:    shares[2] <= cfg_share;
        REG_SHARE_THREE:  shares[3] <= cfg_share;
        default: begin
        end
      endcase
    end
  end

  // Effective number of processes: zero counts as one, excess is clipped.
  assign active_w = AW'(active_count);

  always_comb begin
    if (active_count == '0) begin
      n_w = AW'(1);
    end else if (active_w > AW'(MAX_PROCESSES)) begin
      n_w = AW'(MAX_PROCESSES);
    end else begin
      n_w = active_w;
    end
    n_eff = NW'(n_w);
  end

  // Share of the candidate; processes without a share register hold one share.
  always_comb begin
    share_idx = SHARE_RESET;
    for (int k = 0; k < SHARE_COUNT; k++) begin
      if (int'(idx) == k) begin
        share_idx = shares[k];
      end
    end
  end

  assign used_idx = used_counts[idx];

  // The one multiplier: candidate count times best share, then best count
  // times candidate share.
  assign mul_a   = cmd.mul_rhs ? best_used : used_idx;
  assign mul_b   = cmd.mul_rhs ? share_idx : best_share;
  assign product = PW'(mul_a) * PW'(mul_b);

  assign used_inc  = (best_used == '1) ? best_used : best_used + COUNT_WIDTH'(1);
  assign tick_plus = tick_number + TIME_WIDTH'(1);
  assign any_load  = cmd.load_grant || cmd.load_switch || cmd.load_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_PROCESSES; k++) begin
        used_counts[k] <= '0;
      end
      tick_number     <= '0;
      interval_open   <= 1'b0;
      running_process <= '0;
      interval_start  <= '0;
      rec_valid       <= 1'b0;
    end else begin
      if (cmd.update) begin
        used_counts[best] <= used_inc;
      end
      if (cmd.load_grant && !interval_open) begin
        interval_open   <= 1'b1;
        running_process <= best;
        interval_start  <= tick_number;
      end
      if (cmd.load_switch) begin
        running_process <= best;
        interval_start  <= tick_number;
      end
      if (cmd.load_final) begin
        interval_open <= 1'b0;
      end
      if (cmd.finish) begin
        tick_number <= tick_plus;
      end
      if (any_load) begin
        rec_valid <= 1'b1;
      end else if (rec_ready) begin
        rec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best       <= '0;
      best_used  <= used_counts[0];
      best_share <= shares[0];
      idx        <= IW'(1);
      final_flag <= final_tick;
    end
    if (cmd.mul_lhs) begin
      prod_lhs <= product;
    end
    if (cmd.mul_rhs) begin
      prod_rhs <= product;
    end
    if (cmd.compare) begin
      if (prod_lhs < prod_rhs) begin
        best       <= idx;
        best_used  <= used_idx;
        best_share <= share_idx;
      end
      idx <= idx + IW'(1);
    end
    if (cmd.update) begin
      best_used <= used_inc;
    end
    if (cmd.load_grant) begin
      rec_data.record_kind   <= REC_GRANT;
      rec_data.process_index <= PROC_WIDTH'(best);
      rec_data.used_ticks    <= USED_WIDTH'(best_used);
      rec_data.begin_time    <= tick_number;
      rec_data.end_time      <= tick_plus;
      rec_data.last_of_run   <= 1'b0;
    end
    if (cmd.load_switch) begin
      rec_data.record_kind   <= REC_INTERVAL;
      rec_data.process_index <= PROC_WIDTH'(running_process);
      rec_data.used_ticks    <= '0;
      rec_data.begin_time    <= interval_start;
      rec_data.end_time      <= tick_number;
      rec_data.last_of_run   <= 1'b0;
    end
    if (cmd.load_final) begin
      rec_data.record_kind   <= REC_INTERVAL;
      rec_data.process_index <= PROC_WIDTH'(running_process);
      rec_data.used_ticks    <= '0;
      rec_data.begin_time    <= interval_start;
      rec_data.end_time      <= tick_plus;
      rec_data.last_of_run   <= 1'b1;
    end
  end

  assign status.multi         = (n_eff != NW'(1));
  assign status.last_cand     = ((NW'(idx) + NW'(1)) == n_eff);
  assign status.switch_needed = interval_open && (running_process != best);
  assign status.final_flag    = final_flag;
  assign status.out_free      = !rec_valid || rec_ready;

  a_switch_adopts_best: assert property (@(posedge clk) disable iff (rst)
    cmd.load_switch |=> (running_process == best))
    else $error("interval switch did not adopt the granted process");

  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    cmd.load_final |=> !interval_open)
    else $error("final record left the interval open");

  a_update_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (best_used != '0))
    else $error("granted process has a zero used count after update");

endmodule

`default_nettype wire

// ===== design/pst_controller.sv =====
`default_nettype none

module pst_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pst_pkg::pst_status_t status,
  output pst_pkg::pst_cmd_t         cmd
);
  import pst_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    MUL_L,
    MUL_R,
    CMP,
    UPDATE,
    GRANT,
    SWITCH,
    FINAL
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = status.multi ? MUL_L : UPDATE;
        end
      end
      MUL_L: begin
        cmd.mul_lhs = 1'b1;
        state_next  = MUL_R;
      end
      MUL_R: begin
        cmd.mul_rhs = 1'b1;
        state_next  = CMP;
      end
      CMP: begin
        cmd.compare = 1'b1;
        state_next  = status.last_cand ? UPDATE : MUL_L;
      end
      UPDATE: begin
        cmd.update = 1'b1;
        state_next = GRANT;
      end
      GRANT: begin
        if (status.out_free) begin
          cmd.load_grant = 1'b1;
          if (status.switch_needed) begin
            state_next = SWITCH;
          end else if (status.final_flag) begin
            state_next = FINAL;
          end else begin
            cmd.finish = 1'b1;
            state_next = IDLE;
          end
        end
      end
      SWITCH: begin
        if (status.out_free) begin
          cmd.load_switch = 1'b1;
          if (status.final_flag) begin
            state_next = FINAL;
          end else begin
            cmd.finish = 1'b1;
            state_next = IDLE;
          end
        end
      end
      FINAL: begin
        if (status.out_free) begin
          cmd.load_final = 1'b1;
          cmd.finish     = 1'b1;
          state_next     = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_loads_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.mul_lhs, cmd.mul_rhs, cmd.compare, cmd.update,
              cmd.load_grant || cmd.load_switch || cmd.load_final}))
    else $error("more than one datapath step commanded at once");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_grant || cmd.load_switch || cmd.load_final) |-> status.out_free)
    else $error("record loaded while the output register is full");

  a_finish_with_load: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (cmd.load_grant || cmd.load_switch || cmd.load_final))
    else $error("tick finished without delivering its last record");

endmodule

`default_nettype wire

// ===== design/proportional_share_tick_scheduler.sv =====
`default_nettype none

// Proportional-share tick scheduler. Every accepted transaction on ticks is one
// time tick; the tick is granted to the active process whose ratio of used ticks
// to shares is smallest, compared exactly by cross-multiplication, with ties
// going to the lowest index. Each tick produces a grant record, then an interval
// record when the running process changes, then a closing interval record
// (last_of_run set) when the tick is flagged final, so one tick yields one to
// three transactions on records. One shared multiplier forms the two cross
// products of each candidate in turn and a third step compares them; then the
// used count is updated and each record is loaded into the output register,
// waiting while that register is still full. The next tick is accepted as soon
// as the last record of the previous one sits in the output register. Shares and
// the active count must be written through cfg_we, cfg_index and cfg_data only
// while no tick is in progress, which the block itself does not enforce; a zero
// share counts as one share.
module proportional_share_tick_scheduler #(
  parameter int MAX_PROCESSES = 4,
  parameter int COUNT_WIDTH   = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  pst_chan_if.sink                                  ticks,
  pst_chan_if.source                                records,
  input  wire logic                                 cfg_we,
  input  wire logic [pst_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [pst_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
  import pst_pkg::*;

  // Controller and datapath exchange only these two groups of signals.
  pst_cmd_t    cmd;
  pst_status_t status;
  logic        tick_ready;
  logic        rec_valid;
  pst_rec_t    rec_data;

  pst_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (ticks.valid),
    .in_ready (tick_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pst_datapath #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .final_tick (ticks.data.final_tick),
    .cmd        (cmd),
    .status     (status),
    .rec_valid  (rec_valid),
    .rec_ready  (records.ready),
    .rec_data   (rec_data)
  );

  // The tick channel is ready only while the controller waits for work; the
  // record channel is driven straight from the datapath's output register.
  assign ticks.ready   = tick_ready;
  assign records.valid = rec_valid;
  assign records.data  = rec_data;

endmodule

`default_nettype wire
